>>> hw/rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the bidirectional pair table: opcodes,
// status codes, the slot contents and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package bpt_pkg;

    // number of slots, one cell each
    localparam int ENTRIES = 64;
    localparam int KEY_W   = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_GET_S  = 3'd1,
        OP_GET_F  = 3'd2,
        OP_RM_F   = 3'd3,
        OP_RM_S   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // contents of one slot
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] first;
        logic signed [KEY_W-1:0] second;
    } entry_t;

    // operation in flight, handed from cell to cell
    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] fk;
        logic signed [KEY_W-1:0] sk;
        logic signed [KEY_W-1:0] found;
        logic                    hit;
        logic                    placed;
    } tok_t;

endpackage

>>> hw/rtl/bpt_cell.sv
// ----------------------------------------------------------------------------
// bpt_cell
// One slot of the pair table. Holds a pair and applies the passing token:
// key compare, take-over of the right neighbor's pair during compaction,
// append of a new pair at the first free slot, and clear.
// ----------------------------------------------------------------------------
module bpt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tok_in_vld,
    input  bpt_pkg::tok_t   tok_in,
    input  logic            advance,
    input  bpt_pkg::entry_t nbr,
    output bpt_pkg::entry_t own,
    output logic            tok_out_vld,
    output bpt_pkg::tok_t   tok_out
);

    logic                            valid_reg, valid_next;
    logic signed [bpt_pkg::KEY_W-1:0] first_reg, first_next;
    logic signed [bpt_pkg::KEY_W-1:0] second_reg, second_next;
    logic                            tv_reg, tv_next;
    bpt_pkg::tok_t                   tok_reg, tok_next;

    logic            use_first;
    logic            uses_key;
    logic            moves;
    logic            match;
    logic            new_hit;
    logic            shift;
    bpt_pkg::entry_t ent_next;

    assign own = '{valid: valid_reg, first: first_reg, second: second_reg};

    // opcode decode
    always_comb begin
        use_first = 1'b0;
        uses_key  = 1'b0;
        moves     = 1'b0;
        unique case (tok_reg.op) inside
            bpt_pkg::OP_PUT: begin
                uses_key = 1'b1;
                moves    = 1'b1;
            end
            bpt_pkg::OP_GET_S: begin
                uses_key  = 1'b1;
                use_first = 1'b1;
            end
            bpt_pkg::OP_GET_F: begin
                uses_key = 1'b1;
            end
            bpt_pkg::OP_RM_F: begin
                uses_key  = 1'b1;
                use_first = 1'b1;
                moves     = 1'b1;
            end
            bpt_pkg::OP_RM_S: begin
                uses_key = 1'b1;
                moves    = 1'b1;
            end
            default: begin
                uses_key = 1'b0;
            end
        endcase
    end

    // compare, compaction, append and clear
    always_comb begin
        match   = uses_key && valid_reg &&
                  (use_first ? (first_reg == tok_reg.fk) : (second_reg == tok_reg.sk));
        new_hit = match && !tok_reg.hit;

        tok_out     = tok_reg;
        tok_out.hit = tok_reg.hit | new_hit;
        if (new_hit && tok_reg.op == bpt_pkg::OP_GET_S) begin
            tok_out.found = second_reg;
        end else if (new_hit && tok_reg.op == bpt_pkg::OP_GET_F) begin
            tok_out.found = first_reg;
        end

        // once the doomed pair is passed, every younger pair moves down one slot
        shift    = tok_out.hit && moves;
        ent_next = shift ? nbr : own;

        if (tok_reg.op == bpt_pkg::OP_PUT && !ent_next.valid && !tok_reg.placed) begin
            ent_next       = '{valid: 1'b1, first: tok_reg.fk, second: tok_reg.sk};
            tok_out.placed = 1'b1;
        end
        if (tok_reg.op == bpt_pkg::OP_CLEAR) begin
            ent_next.valid = 1'b0;
        end
    end

    assign tok_out_vld = tv_reg && advance;

    // next state of slot and token holder
    always_comb begin
        valid_next  = valid_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (tok_out_vld) begin
            valid_next  = ent_next.valid;
            first_next  = ent_next.first;
            second_next = ent_next.second;
        end
        tv_next  = tv_reg;
        tok_next = tok_reg;
        if (tok_in_vld) begin
            tv_next  = 1'b1;
            tok_next = tok_in;
        end else if (advance) begin
            tv_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tv_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            tv_reg    <= tv_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        first_reg  <= first_next;
        second_reg <= second_next;
        tok_reg    <= tok_next;
    end

endmodule

>>> hw/rtl/bidirectional_pair_table.sv
// ----------------------------------------------------------------------------
// bidirectional_pair_table
// Bounded table of (first, second) key pairs searchable by either key,
// built as a row of slot cells that an operation token walks through.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one operation beat (op, first key, second key);
//   the m_ channel returns one result beat (status, found value) for it.
//   An accepted beat enters cell 0 and moves one cell per cycle, but the
//   last cell holds it while the output register has an untaken result; each
//   cell compares, compacts, appends or clears its own slot on the way. The
//   result is loaded into the output register as the token leaves the last
//   cell, and the next beat is taken only once the result is there.
//   Only one operation is in the row at a time; s_ready is low meanwhile.
//   A finished result waits in the output register while a new beat is
//   taken; if the receiver stalls, the next token holds in the last cell
//   until the output register frees.
//   Reset empties the table (all slot valid bits cleared) and drops any
//   beat in flight; the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module bidirectional_pair_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bpt_pkg::OP_W-1:0]         s_op,
    input  logic signed [bpt_pkg::KEY_W-1:0] s_first_key,
    input  logic signed [bpt_pkg::KEY_W-1:0] s_second_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bpt_pkg::ST_W-1:0]         m_status,
    output logic signed [bpt_pkg::KEY_W-1:0] m_found_value
);

    logic                              busy_reg, busy_next;
    logic                              mv_reg, mv_next;
    logic [bpt_pkg::ST_W-1:0]          status_reg, status_next;
    logic signed [bpt_pkg::KEY_W-1:0]  found_reg, found_next;

    logic                  out_free;
    logic                  s_beat;
    bpt_pkg::tok_t         tok_first;
    logic                  tv   [bpt_pkg::ENTRIES+1];
    bpt_pkg::tok_t         toks [bpt_pkg::ENTRIES+1];
    bpt_pkg::entry_t       ents [bpt_pkg::ENTRIES+1];
    bpt_pkg::status_t      fin_status;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = !busy_reg;
    assign s_beat   = s_valid && s_ready;

    // token for a new beat
    always_comb begin
        tok_first        = '0;
        tok_first.op     = bpt_pkg::op_t'(s_op);
        tok_first.fk     = s_first_key;
        tok_first.sk     = s_second_key;
        tok_first.found  = '0;
        tok_first.hit    = 1'b0;
        tok_first.placed = 1'b0;
    end

    assign tv[0]                   = s_beat;
    assign toks[0]                 = tok_first;
    assign ents[bpt_pkg::ENTRIES]  = '0;

    // row of slot cells
    for (genvar i = 0; i < bpt_pkg::ENTRIES; i++) begin : g_cell
        bpt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tok_in_vld  (tv[i]),
            .tok_in      (toks[i]),
            .advance     ((i == bpt_pkg::ENTRIES - 1) ? out_free : 1'b1),
            .nbr         (ents[i+1]),
            .own         (ents[i]),
            .tok_out_vld (tv[i+1]),
            .tok_out     (toks[i+1])
        );
    end

    // result status from the finished token
    always_comb begin
        unique case (toks[bpt_pkg::ENTRIES].op) inside
            bpt_pkg::OP_PUT:
                fin_status = toks[bpt_pkg::ENTRIES].placed ? bpt_pkg::ST_OK
                                                           : bpt_pkg::ST_FULL;
            bpt_pkg::OP_GET_S, bpt_pkg::OP_GET_F, bpt_pkg::OP_RM_F, bpt_pkg::OP_RM_S:
                fin_status = toks[bpt_pkg::ENTRIES].hit ? bpt_pkg::ST_OK
                                                        : bpt_pkg::ST_NONE;
            bpt_pkg::OP_CLEAR:
                fin_status = bpt_pkg::ST_OK;
            default:
                fin_status = bpt_pkg::ST_NONE;
        endcase
    end

    // busy flag and output register
    always_comb begin
        busy_next   = busy_reg;
        mv_next     = mv_reg;
        status_next = status_reg;
        found_next  = found_reg;
        if (s_beat) begin
            busy_next = 1'b1;
        end else if (tv[bpt_pkg::ENTRIES]) begin
            busy_next = 1'b0;
        end
        if (tv[bpt_pkg::ENTRIES]) begin
            mv_next     = 1'b1;
            status_next = fin_status;
            found_next  = toks[bpt_pkg::ENTRIES].found;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign m_valid       = mv_reg;
    assign m_status      = status_reg;
    assign m_found_value = found_reg;

endmodule

>>> hw/rtl/bpt_checker.sv
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks for the bidirectional pair table, bound to the top.
// ----------------------------------------------------------------------------
module bpt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [bpt_pkg::ST_W-1:0]         m_status,
    input logic signed [bpt_pkg::KEY_W-1:0] m_found_value
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_value))
        else $error("result beat changed while stalled");

    // one operation at a time in the cell row
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an operation is in flight");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == bpt_pkg::ST_OK || m_status == bpt_pkg::ST_NONE ||
                     m_status == bpt_pkg::ST_FULL))
        else $error("undefined status code");

    // a partner value is only returned with an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found_value != 0 |-> m_status == bpt_pkg::ST_OK)
        else $error("found value with a failing status");

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat survived reset");

endmodule

bind bidirectional_pair_table bpt_checker u_bpt_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bidirectional_pair_table. Operation beats go in
// over the s_ channel in bursts; every accepted beat is run through a
// behavioral copy of the pair table and its status and found value are
// queued. Result beats on the m_ channel are matched in order against that
// queue. A short hand-written table opens the run, then random episodes
// fill the table past capacity, churn it, drain it and throw noise at it.
// ----------------------------------------------------------------------------
module tb;
    import bpt_pkg::*;

    // opcodes the package leaves unnamed, both must act as no-ops
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    localparam int POOL_N      = 48;
    localparam int RAND_ITEMS  = 1800;
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic signed [KEY_W-1:0] first;
        logic signed [KEY_W-1:0] second;
    } pair_t;

    typedef struct {
        logic [ST_W-1:0]         st;
        logic signed [KEY_W-1:0] fv;
        logic [OP_W-1:0]         op;
        int                      tag;
    } result_t;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] fk;
        logic signed [KEY_W-1:0] sk;
        bit                      known;
        logic [ST_W-1:0]         st;
        logic signed [KEY_W-1:0] fv;
    } stim_row_t;

    typedef enum int {RX_STEADY, RX_MOSTLY, RX_PERIODIC, RX_COIN} rx_mode_t;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op         = '0;
    logic signed [KEY_W-1:0]   s_first_key  = '0;
    logic signed [KEY_W-1:0]   s_second_key = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic [ST_W-1:0]           m_status;
    logic signed [KEY_W-1:0]   m_found_value;

    // live pairs of the table, oldest first
    pair_t                   live_pairs[$];
    result_t                 results_due[$];
    logic signed [KEY_W-1:0] key_pool[POOL_N];

    int errors         = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int burst_left     = 1;
    int puts_done      = 0;
    int puts_refused   = 0;
    int get_hits       = 0;
    int peak_fill      = 0;
    int holds_done     = 0;
    bit hold_request   = 1'b0;

    always #4 aclk = ~aclk;

    bidirectional_pair_table DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_first_key   (s_first_key),
        .s_second_key  (s_second_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value)
    );

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic int slot_of_first(input logic signed [KEY_W-1:0] key);
        foreach (live_pairs[i]) begin
            if (live_pairs[i].first == key) return i;
        end
        return -1;
    endfunction

    function automatic int slot_of_second(input logic signed [KEY_W-1:0] key);
        foreach (live_pairs[i]) begin
            if (live_pairs[i].second == key) return i;
        end
        return -1;
    endfunction

    // apply one operation to the pair table and return its result beat
    function automatic void predict_pair_op(input logic [OP_W-1:0] op,
                                            input logic signed [KEY_W-1:0] fk,
                                            input logic signed [KEY_W-1:0] sk,
                                            output logic [ST_W-1:0] st,
                                            output logic signed [KEY_W-1:0] fv);
        int    pos;
        pair_t p;
        st = ST_NONE;
        fv = '0;
        case (op)
            OP_PUT: begin
                pos = slot_of_second(sk);
                if (pos < 0 && live_pairs.size() >= ENTRIES) begin
                    st = ST_FULL;
                    puts_refused++;
                end else begin
                    // same second key is replaced, the new pair goes last
                    if (pos >= 0) live_pairs.delete(pos);
                    p.first  = fk;
                    p.second = sk;
                    live_pairs.push_back(p);
                    st = ST_OK;
                    puts_done++;
                    if (live_pairs.size() > peak_fill) peak_fill = live_pairs.size();
                end
            end
            OP_GET_S: begin
                pos = slot_of_first(fk);
                if (pos >= 0) begin
                    st = ST_OK;
                    fv = live_pairs[pos].second;
                    get_hits++;
                end
            end
            OP_GET_F: begin
                pos = slot_of_second(sk);
                if (pos >= 0) begin
                    st = ST_OK;
                    fv = live_pairs[pos].first;
                    get_hits++;
                end
            end
            OP_RM_F: begin
                pos = slot_of_first(fk);
                if (pos >= 0) begin
                    live_pairs.delete(pos);
                    st = ST_OK;
                end
            end
            OP_RM_S: begin
                pos = slot_of_second(sk);
                if (pos >= 0) begin
                    live_pairs.delete(pos);
                    st = ST_OK;
                end
            end
            OP_CLEAR: begin
                live_pairs.delete();
                st = ST_OK;
            end
            default: st = ST_NONE;
        endcase
    endfunction

    // half the time keys already in the table so searches hit, else pool or raw
    function automatic logic signed [KEY_W-1:0] pick_key(input bit want_second);
        int    r;
        pair_t p;
        r = $urandom_range(0, 9);
        if (r < 5 && live_pairs.size() > 0) begin
            p = live_pairs[$urandom_range(0, live_pairs.size() - 1)];
            return want_second ? p.second : p.first;
        end
        if (r < 9) return key_pool[$urandom_range(0, POOL_N - 1)];
        return $signed($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 36) return OP_PUT;
        if (r < 50) return OP_GET_S;
        if (r < 64) return OP_GET_F;
        if (r < 77) return OP_RM_F;
        if (r < 90) return OP_RM_S;
        if (r < 93) return OP_CLEAR;
        return (r < 97) ? OP_RSVD6 : OP_RSVD7;
    endfunction

    // offer one beat, wait for acceptance, queue its result, maybe pause
    task automatic issue(input logic [OP_W-1:0] op,
                         input logic signed [KEY_W-1:0] fk,
                         input logic signed [KEY_W-1:0] sk,
                         input bit known = 1'b0,
                         input logic [ST_W-1:0] k_st = ST_NONE,
                         input logic signed [KEY_W-1:0] k_fv = '0);
        result_t due;
        int      gap;
        s_valid      <= 1'b1;
        s_op         <= op;
        s_first_key  <= fk;
        s_second_key <= sk;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_pair_op(op, fk, sk, due.st, due.fv);
        if (known) begin
            due.st = k_st;
            due.fv = k_fv;
        end
        due.op  = op;
        due.tag = items_sent;
        results_due.push_back(due);
        items_sent++;
        // end of burst: drop valid for a short or a long gap
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                              : $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        result_t due;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                report($sformatf("result beat status %0d value %0d with nothing pending",
                                 m_status, m_found_value));
            end else begin
                due = results_due.pop_front();
                if (m_status !== due.st) begin
                    report($sformatf("beat %0d op %0d: status %0d, expected %0d",
                                     due.tag, due.op, m_status, due.st));
                end
                if (m_found_value !== due.fv) begin
                    report($sformatf("beat %0d op %0d: found value %0d, expected %0d",
                                     due.tag, due.op, m_found_value, due.fv));
                end
            end
        end
    end

    // receiver: changing stall patterns plus one long counted hold
    initial begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode      = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(100, 600);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_STEADY:   m_ready <= 1'b1;
                    RX_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: m_ready <= (phase % 5 == 0);
                    default:     m_ready <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        stim_row_t               dir_rows[$];
        stim_row_t               row;
        pair_t                   p;
        logic signed [KEY_W-1:0] sk;
        int                      pick;
        int                      dir_n;
        bit                      hold_asked;
        hold_asked = 1'b0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (int i = 5; i < POOL_N; i++) key_pool[i] = $signed($urandom);

        // empty table, extremes, replacement, oldest-first, no-op codes, clear
        dir_rows.push_back('{OP_GET_S, 32'sd0,   32'sd0,   1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_GET_F, 32'sd0,   32'sd0,   1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_RM_F,  32'sd0,   32'sd0,   1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_RM_S,  32'sd0,   32'sd0,   1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_PUT,   KEY_MIN,  KEY_MAX,  1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_GET_S, KEY_MIN,  32'sd0,   1'b1, ST_OK,   KEY_MAX});
        dir_rows.push_back('{OP_GET_F, 32'sd0,   KEY_MAX,  1'b1, ST_OK,   KEY_MIN});
        dir_rows.push_back('{OP_PUT,   KEY_MAX,  KEY_MIN,  1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_GET_F, 32'sd0,   KEY_MIN,  1'b1, ST_OK,   KEY_MAX});
        dir_rows.push_back('{OP_PUT,   -32'sd1,  KEY_MAX,  1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_GET_S, KEY_MIN,  32'sd0,   1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_GET_F, 32'sd0,   KEY_MAX,  1'b1, ST_OK,   -32'sd1});
        dir_rows.push_back('{OP_PUT,   32'sd7,   32'sd1,   1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_PUT,   32'sd7,   32'sd2,   1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_GET_S, 32'sd7,   32'sd0,   1'b1, ST_OK,   32'sd1});
        dir_rows.push_back('{OP_RM_F,  32'sd7,   32'sd0,   1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_GET_S, 32'sd7,   32'sd0,   1'b1, ST_OK,   32'sd2});
        dir_rows.push_back('{OP_RM_S,  32'sd0,   32'sd2,   1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_RM_S,  32'sd0,   32'sd2,   1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_RSVD6, -32'sd1,  -32'sd1,  1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_RSVD7, KEY_MAX,  KEY_MIN,  1'b1, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_GET_S, $signed($urandom), $signed($urandom),
                             1'b0, ST_NONE, 32'sd0});
        dir_rows.push_back('{OP_GET_S, KEY_MAX,  32'sd0,   1'b1, ST_OK,   KEY_MIN});
        dir_rows.push_back('{OP_CLEAR, KEY_MIN,  KEY_MAX,  1'b1, ST_OK,   32'sd0});
        dir_rows.push_back('{OP_GET_F, 32'sd0,   KEY_MAX,  1'b1, ST_NONE, 32'sd0});
        dir_n = dir_rows.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            issue(row.op, row.fk, row.sk, row.known, row.st, row.fv);
        end

        while (items_sent < dir_n + RAND_ITEMS) begin
            // once, a third of the way in, make the receiver sit still
            if (!hold_asked && items_sent >= dir_n + RAND_ITEMS / 3) begin
                hold_asked   = 1'b1;
                hold_request = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                // fill to capacity, push past it, then work the full table
                if ($urandom_range(0, 1) == 0) issue(OP_CLEAR, pick_key(0), pick_key(1));
                while (live_pairs.size() < ENTRIES) begin
                    do sk = $signed($urandom); while (slot_of_second(sk) >= 0);
                    issue(OP_PUT, pick_key(0), sk);
                end
                repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        do sk = $signed($urandom); while (slot_of_second(sk) >= 0);
                    end else begin
                        sk = live_pairs[$urandom_range(0, live_pairs.size() - 1)].second;
                    end
                    issue(OP_PUT, pick_key(0), sk);
                end
                repeat ($urandom_range(5, 15)) issue(pick_op(), pick_key(0), pick_key(1));
            end else if (pick < 8) begin
                // general churn
                repeat ($urandom_range(20, 80)) issue(pick_op(), pick_key(0), pick_key(1));
            end else if (pick == 8) begin
                // noise: any code, raw keys
                repeat ($urandom_range(5, 15)) begin
                    issue(OP_W'($urandom_range(0, 7)), $signed($urandom), $signed($urandom));
                end
            end else begin
                // drain by either key, then issue three random operations on the empty table
                while (live_pairs.size() > 0) begin
                    p = live_pairs[$urandom_range(0, live_pairs.size() - 1)];
                    if ($urandom_range(0, 1) == 0) issue(OP_RM_F, p.first, pick_key(1));
                    else issue(OP_RM_S, pick_key(0), p.second);
                end
                repeat (3) issue(pick_op(), pick_key(0), pick_key(1));
            end
        end

        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (2 * ENTRIES + 8) @(posedge aclk);

        $display("ran %0d operations: %0d puts stored, %0d refused on a full table, %0d get hits",
                 items_sent, puts_done, puts_refused, get_hits);
        $display("table peaked at %0d of %0d pairs; %0d result beats checked, %0d long holds",
                 peak_fill, ENTRIES, results_seen, holds_done);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, many times the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/bpt_pkg.sv
hw/rtl/bpt_cell.sv
hw/rtl/bidirectional_pair_table.sv
hw/rtl/bpt_checker.sv
test/tb.sv
